@@ src/tick_timer_and_line_counter_core_macros.svh @@
// Assertion helpers for the checker file.
`ifndef TICK_TIMER_AND_LINE_COUNTER_CORE_MACROS_SVH
`define TICK_TIMER_AND_LINE_COUNTER_CORE_MACROS_SVH

// Checked only outside reset.
`define TTLC_CHK_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked on every edge, reset included.
`define TTLC_CHK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ttlc_pkg.sv @@
package ttlc_pkg;

    localparam int TICKS_PER_FRAME = 70224;
    localparam int DOTS_PER_LINE   = 456;
    localparam int LINES_PER_FRAME = 154;

    localparam int FC_W      = $clog2(TICKS_PER_FRAME);
    localparam int DOT_W     = $clog2(DOTS_PER_LINE);
    localparam int FLINE_W   = $clog2(TICKS_PER_FRAME / DOTS_PER_LINE + 1);
    localparam int LINE_W    = 8;
    localparam int CMP_W     = (FLINE_W > LINE_W) ? FLINE_W : LINE_W;
    localparam int TICK_W    = 4;
    localparam int CNT_W     = 8;
    localparam int TCTL_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int TCTL_EN_BIT = 2;
    localparam int DIV_STEP    = 256;

    localparam logic [FC_W-1:0]   LAST_FRAME = FC_W'(TICKS_PER_FRAME - 1);
    localparam logic [DOT_W-1:0]  LAST_DOT   = DOT_W'(DOTS_PER_LINE - 1);
    localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(LINES_PER_FRAME - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_CONTROL,
        CFG_TIMER_RELOAD,
        CFG_LINE_COMPARE
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef enum logic [1:0] {
        RATE_1024,
        RATE_16,
        RATE_64,
        RATE_256
    } t_rate;

    // Architectural state plus the incremental form of frame / dots-per-line.
    typedef struct packed {
        logic [FC_W-1:0]    frame;
        logic [FC_W-1:0]    next_div;
        logic [FC_W-1:0]    next_tim;
        logic [CNT_W-1:0]   div;
        logic [CNT_W-1:0]   tim;
        logic [LINE_W-1:0]  line;
        logic [DOT_W-1:0]   dot;
        logic [FLINE_W-1:0] fline;
    } t_tick_state;

    typedef struct packed {
        logic ovf;
        logic match;
        logic fend;
    } t_tick_flags;

    typedef struct packed {
        logic [LINE_W-1:0] line_count;
        logic [CNT_W-1:0]  divider_value;
        logic [CNT_W-1:0]  timer_value;
        logic              timer_overflowed;
        logic              line_matched;
        logic              frame_ended;
    } t_result;

    function automatic logic [FC_W:0] period_of(input logic [1:0] sel);
        logic [FC_W:0] p;
        case (t_rate'(sel))
            RATE_1024: p = (FC_W+1)'(1024);
            RATE_16:   p = (FC_W+1)'(16);
            RATE_64:   p = (FC_W+1)'(64);
            default:   p = (FC_W+1)'(256);
        endcase
        return p;
    endfunction

    // (a + b) mod frame length; a is below the frame length, b no more than it.
    function automatic logic [FC_W-1:0] mod_add(input logic [FC_W-1:0] a,
                                                input logic [FC_W:0]   b);
        logic [FC_W:0] s;
        s = {1'b0, a} + b;
        if (s >= (FC_W+1)'(TICKS_PER_FRAME)) begin
            s = s - (FC_W+1)'(TICKS_PER_FRAME);
        end
        return s[FC_W-1:0];
    endfunction

endpackage

@@ src/ttlc_in_if.sv @@
interface ttlc_in_if;
    import ttlc_pkg::*;

    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] tick_count;

    modport source (output valid, output tick_count, input ready);
    modport sink   (input valid, input tick_count, output ready);
endinterface

@@ src/ttlc_out_if.sv @@
interface ttlc_out_if;
    import ttlc_pkg::*;

    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] line_count;
    logic [CNT_W-1:0]  divider_value;
    logic [CNT_W-1:0]  timer_value;
    logic              timer_overflowed;
    logic              line_matched;
    logic              frame_ended;

    modport source (output valid, output line_count, output divider_value,
                    output timer_value, output timer_overflowed,
                    output line_matched, output frame_ended, input ready);
    modport sink   (input valid, input line_count, input divider_value,
                    input timer_value, input timer_overflowed,
                    input line_matched, input frame_ended, output ready);
endinterface

@@ src/ttlc_tick.sv @@
// One tick of the frame: line, compare, divider, timer, frame cycle.
module ttlc_tick (
    input  ttlc_pkg::t_tick_state           i_cur,
    input  logic [ttlc_pkg::TCTL_W-1:0]     i_tctl,
    input  logic [ttlc_pkg::CNT_W-1:0]      i_reload,
    input  logic [ttlc_pkg::LINE_W-1:0]     i_lcmp,
    output ttlc_pkg::t_tick_state           o_nxt,
    output ttlc_pkg::t_tick_flags           o_flags
);
    import ttlc_pkg::*;

    always_comb begin
        o_nxt   = i_cur;
        o_flags = '0;

        // line counter chases frame / dots-per-line
        if (CMP_W'(i_cur.fline) > CMP_W'(i_cur.line)) begin
            o_nxt.line = (i_cur.line == LAST_LINE) ? '0 : i_cur.line + 1'b1;
        end

        o_flags.match = (o_nxt.line == i_lcmp);

        if (i_cur.frame == i_cur.next_div) begin
            o_nxt.div      = i_cur.div + 1'b1;
            o_nxt.next_div = mod_add(i_cur.frame, (FC_W+1)'(DIV_STEP));
        end

        if (i_tctl[TCTL_EN_BIT] && (i_cur.frame == i_cur.next_tim)) begin
            if (i_cur.tim == '1) begin
                o_nxt.tim   = i_reload;
                o_flags.ovf = 1'b1;
            end else begin
                o_nxt.tim = i_cur.tim + 1'b1;
            end
            o_nxt.next_tim = mod_add(i_cur.frame, period_of(i_tctl[1:0]));
        end

        if (i_cur.frame == LAST_FRAME) begin
            o_nxt.frame  = '0;
            o_nxt.line   = '0;
            o_nxt.dot    = '0;
            o_nxt.fline  = '0;
            o_flags.fend = 1'b1;
        end else begin
            o_nxt.frame = i_cur.frame + 1'b1;
            if (i_cur.dot == LAST_DOT) begin
                o_nxt.dot   = '0;
                o_nxt.fline = i_cur.fline + 1'b1;
            end else begin
                o_nxt.dot = i_cur.dot + 1'b1;
            end
        end
    end

endmodule

@@ src/tick_timer_and_line_counter_core.sv @@
// Tick timer and line counter. Each input word carries a tick count; the core
// walks those ticks one per clock through a single tick datapath (divider,
// reloading timer, line counter, frame cycle) and then posts one result word
// with the counters and the sticky overflow, line-match and frame-end flags
// gathered over the item. The input stays closed from acceptance until the
// result is posted, and longer only while the previous result has not yet
// been taken. Configuration writes go straight to the control, reload and
// compare registers and should be made while idle.
module tick_timer_and_line_counter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ttlc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ttlc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ttlc_in_if.sink                           i_in,
    ttlc_out_if.source                        o_out
);
    import ttlc_pkg::*;

    // config registers
    logic [TCTL_W-1:0] r_tctl;
    logic [CNT_W-1:0]  r_reload;
    logic [LINE_W-1:0] r_lcmp;

    // sequencer
    t_state            r_state, n_state;
    logic [TICK_W-1:0] r_left,  n_left;

    // tick state and sticky flags for the word in flight
    t_tick_state r_st,    n_st,    tick_nxt;
    t_tick_flags r_flags, n_flags, tick_flags;

    // output register
    logic    r_out_valid, n_out_valid;
    t_result r_res,       n_res;

    ttlc_tick u_tick (
        .i_cur    (r_st),
        .i_tctl   (r_tctl),
        .i_reload (r_reload),
        .i_lcmp   (r_lcmp),
        .o_nxt    (tick_nxt),
        .o_flags  (tick_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tctl   <= '0;
            r_reload <= '0;
            r_lcmp   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMER_CONTROL: r_tctl   <= i_cfg_data[TCTL_W-1:0];
                CFG_TIMER_RELOAD:  r_reload <= i_cfg_data[CNT_W-1:0];
                CFG_LINE_COMPARE:  r_lcmp   <= i_cfg_data[LINE_W-1:0];
                default: ;  // no register there
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
        end else begin
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_st        <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_st        <= n_st;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_st        = r_st;
        n_flags     = r_flags;
        n_out_valid = r_out_valid;
        n_res       = r_res;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_left  = i_in.tick_count;
                    n_flags = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_left != '0) begin
                    // one tick per clock
                    n_st    = tick_nxt;
                    n_flags = t_tick_flags'(r_flags | tick_flags);
                    n_left  = r_left - 1'b1;
                end else if (!r_out_valid || o_out.ready) begin
                    // post once the output slot is free
                    n_out_valid            = 1'b1;
                    n_res.line_count       = r_st.line;
                    n_res.divider_value    = r_st.div;
                    n_res.timer_value      = r_st.tim;
                    n_res.timer_overflowed = r_flags.ovf;
                    n_res.line_matched     = r_flags.match;
                    n_res.frame_ended      = r_flags.fend;
                    n_state                = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready             = (r_state == S_IDLE);

    assign o_out.valid            = r_out_valid;
    assign o_out.line_count       = r_res.line_count;
    assign o_out.divider_value    = r_res.divider_value;
    assign o_out.timer_value      = r_res.timer_value;
    assign o_out.timer_overflowed = r_res.timer_overflowed;
    assign o_out.line_matched     = r_res.line_matched;
    assign o_out.frame_ended      = r_res.frame_ended;

endmodule

@@ src/ttlc_checker.sv @@
`include "tick_timer_and_line_counter_core_macros.svh"

module ttlc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ttlc_pkg::LINE_W-1:0]   i_line_count,
    input logic [ttlc_pkg::CNT_W-1:0]    i_divider_value,
    input logic [ttlc_pkg::CNT_W-1:0]    i_timer_value
);
    import ttlc_pkg::*;

    // a word is worked on alone: input closes right after acceptance
    `TTLC_CHK_ON(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input still open after accept")

    // line count stays inside the frame
    `TTLC_CHK_ON(a_line_range, i_clk, i_rst_n, i_out_valid |-> (i_line_count < LINE_W'(LINES_PER_FRAME)), "line count out of range")

    // stalled result holds
    `TTLC_CHK_ON(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_line_count) && $stable(i_divider_value) && $stable(i_timer_value)), "stalled result changed")

    // reset leaves the core empty and open
    `TTLC_CHK_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!i_out_valid && i_in_ready), "core not idle after reset")

endmodule

bind tick_timer_and_line_counter_core ttlc_checker u_ttlc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_line_count    (o_out.line_count),
    .i_divider_value (o_out.divider_value),
    .i_timer_value   (o_out.timer_value)
);
